// File: rtl/mpk_pkg.sv
`default_nettype none

package mpk_pkg;

    // Token selector codes.
    localparam logic [3:0] FN_NIL   = 4'd0;
    localparam logic [3:0] FN_BOOL  = 4'd1;
    localparam logic [3:0] FN_INT   = 4'd2;
    localparam logic [3:0] FN_UINT  = 4'd3;
    localparam logic [3:0] FN_FLOAT = 4'd4;
    localparam logic [3:0] FN_STR   = 4'd5;
    localparam logic [3:0] FN_BIN   = 4'd6;
    localparam logic [3:0] FN_ARRAY = 4'd7;
    localparam logic [3:0] FN_MAP   = 4'd8;
    localparam logic [3:0] FN_EXT   = 4'd9;
    localparam logic [3:0] FN_BYTE  = 4'd10;

    // MessagePack format codes.
    localparam logic [7:0] C_FIXMAP   = 8'h80;
    localparam logic [7:0] C_FIXARR   = 8'h90;
    localparam logic [7:0] C_FIXSTR   = 8'ha0;
    localparam logic [7:0] C_NIL      = 8'hc0;
    localparam logic [7:0] C_FALSE    = 8'hc2;
    localparam logic [7:0] C_TRUE     = 8'hc3;
    localparam logic [7:0] C_BIN8     = 8'hc4;
    localparam logic [7:0] C_BIN16    = 8'hc5;
    localparam logic [7:0] C_BIN32    = 8'hc6;
    localparam logic [7:0] C_EXT8     = 8'hc7;
    localparam logic [7:0] C_EXT16    = 8'hc8;
    localparam logic [7:0] C_EXT32    = 8'hc9;
    localparam logic [7:0] C_FLOAT64  = 8'hcb;
    localparam logic [7:0] C_UINT8    = 8'hcc;
    localparam logic [7:0] C_UINT16   = 8'hcd;
    localparam logic [7:0] C_UINT32   = 8'hce;
    localparam logic [7:0] C_UINT64   = 8'hcf;
    localparam logic [7:0] C_INT8     = 8'hd0;
    localparam logic [7:0] C_INT16    = 8'hd1;
    localparam logic [7:0] C_INT32    = 8'hd2;
    localparam logic [7:0] C_INT64    = 8'hd3;
    localparam logic [7:0] C_FIXEXT1  = 8'hd4;
    localparam logic [7:0] C_FIXEXT2  = 8'hd5;
    localparam logic [7:0] C_FIXEXT4  = 8'hd6;
    localparam logic [7:0] C_FIXEXT8  = 8'hd7;
    localparam logic [7:0] C_FIXEXT16 = 8'hd8;
    localparam logic [7:0] C_STR8     = 8'hd9;
    localparam logic [7:0] C_STR16    = 8'hda;
    localparam logic [7:0] C_STR32    = 8'hdb;
    localparam logic [7:0] C_ARR16    = 8'hdc;
    localparam logic [7:0] C_ARR32    = 8'hdd;
    localparam logic [7:0] C_MAP16    = 8'hde;
    localparam logic [7:0] C_MAP32    = 8'hdf;

    localparam int MaxBytes = 9;

    // Encoded sequence, first byte in the top byte lane, with its byte count.
    typedef struct packed {
        logic [8*MaxBytes-1:0] bytes;
        logic [3:0]            count;
    } enc_t;

    // A format code followed by nb big-endian data bytes (nb is 0, 1, 2, 4 or 8).
    function automatic enc_t pack_item(logic [7:0] code, logic [63:0] data, logic [3:0] nb);
        enc_t r;
        r.count = nb + 4'd1;
        case (nb)
            4'd1:    r.bytes = {code, data[7:0], 56'h0};
            4'd2:    r.bytes = {code, data[15:0], 48'h0};
            4'd4:    r.bytes = {code, data[31:0], 32'h0};
            4'd8:    r.bytes = {code, data};
            default: r.bytes = {code, 64'h0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpk_encode.sv
`default_nettype none

module mpk_encode (
    input  wire logic [3:0]         func,
    input  wire logic [63:0]        value,
    input  wire logic signed [7:0]  ext_type,
    output mpk_pkg::enc_t           enc
);
    import mpk_pkg::*;

    logic [31:0] len;
    logic        s_fix;
    logic        s_fit8;
    logic        s_fit16;
    logic        s_fit32;
    logic        len_le15;
    logic        len_le31;
    logic        len_le255;
    logic        len_le65535;

    assign len = value[31:0];

    // A signed value fits n bits when all bits from n-1 upward are equal.
    assign s_fix   = (value[63:7] == '0) || (value[63:5] == '1);
    assign s_fit8  = (value[63:7] == '0) || (value[63:7] == '1);
    assign s_fit16 = (value[63:15] == '0) || (value[63:15] == '1);
    assign s_fit32 = (value[63:31] == '0) || (value[63:31] == '1);

    assign len_le15    = (len[31:4] == '0);
    assign len_le31    = (len[31:5] == '0);
    assign len_le255   = (len[31:8] == '0);
    assign len_le65535 = (len[31:16] == '0);

    always_comb
    begin
        enc = '0;
        case (func)
            FN_NIL:
            begin
                enc = pack_item(C_NIL, 64'h0, 4'd0);
            end
            FN_BOOL:
            begin
                enc = pack_item((value != '0) ? C_TRUE : C_FALSE, 64'h0, 4'd0);
            end
            FN_INT:
            begin
                if (s_fix)
                begin
                    enc.bytes = {value[7:0], 64'h0};
                    enc.count = 4'd1;
                end
                else if (s_fit8)
                    enc = pack_item(C_INT8, value, 4'd1);
                else if (s_fit16)
                    enc = pack_item(C_INT16, value, 4'd2);
                else if (s_fit32)
                    enc = pack_item(C_INT32, value, 4'd4);
                else
                    enc = pack_item(C_INT64, value, 4'd8);
            end
            FN_UINT:
            begin
                if (value[63:7] == '0)
                begin
                    enc.bytes = {value[7:0], 64'h0};
                    enc.count = 4'd1;
                end
                else if (value[63:8] == '0)
                    enc = pack_item(C_UINT8, value, 4'd1);
                else if (value[63:16] == '0)
                    enc = pack_item(C_UINT16, value, 4'd2);
                else if (value[63:32] == '0)
                    enc = pack_item(C_UINT32, value, 4'd4);
                else
                    enc = pack_item(C_UINT64, value, 4'd8);
            end
            FN_FLOAT:
            begin
                enc = pack_item(C_FLOAT64, value, 4'd8);
            end
            FN_STR:
            begin
                if (len_le31)
                    enc = pack_item(C_FIXSTR | {3'b000, len[4:0]}, 64'h0, 4'd0);
                else if (len_le255)
                    enc = pack_item(C_STR8, value, 4'd1);
                else if (len_le65535)
                    enc = pack_item(C_STR16, value, 4'd2);
                else
                    enc = pack_item(C_STR32, value, 4'd4);
            end
            FN_BIN:
            begin
                if (len_le255)
                    enc = pack_item(C_BIN8, value, 4'd1);
                else if (len_le65535)
                    enc = pack_item(C_BIN16, value, 4'd2);
                else
                    enc = pack_item(C_BIN32, value, 4'd4);
            end
            FN_ARRAY:
            begin
                if (len_le15)
                    enc = pack_item(C_FIXARR | {4'b0000, len[3:0]}, 64'h0, 4'd0);
                else if (len_le65535)
                    enc = pack_item(C_ARR16, value, 4'd2);
                else
                    enc = pack_item(C_ARR32, value, 4'd4);
            end
            FN_MAP:
            begin
                if (len_le15)
                    enc = pack_item(C_FIXMAP | {4'b0000, len[3:0]}, 64'h0, 4'd0);
                else if (len_le65535)
                    enc = pack_item(C_MAP16, value, 4'd2);
                else
                    enc = pack_item(C_MAP32, value, 4'd4);
            end
            FN_EXT:
            begin
                // The type byte follows the format code, or the length field where there is one.
                case (len)
                    32'd1:   enc = pack_item(C_FIXEXT1, {56'h0, ext_type}, 4'd1);
                    32'd2:   enc = pack_item(C_FIXEXT2, {56'h0, ext_type}, 4'd1);
                    32'd4:   enc = pack_item(C_FIXEXT4, {56'h0, ext_type}, 4'd1);
                    32'd8:   enc = pack_item(C_FIXEXT8, {56'h0, ext_type}, 4'd1);
                    32'd16:  enc = pack_item(C_FIXEXT16, {56'h0, ext_type}, 4'd1);
                    default:
                    begin
                        if (len_le255)
                        begin
                            enc.bytes = {C_EXT8, len[7:0], ext_type, 48'h0};
                            enc.count = 4'd3;
                        end
                        else if (len_le65535)
                        begin
                            enc.bytes = {C_EXT16, len[15:0], ext_type, 40'h0};
                            enc.count = 4'd4;
                        end
                        else
                        begin
                            enc.bytes = {C_EXT32, len, ext_type, 24'h0};
                            enc.count = 4'd6;
                        end
                    end
                endcase
            end
            FN_BYTE:
            begin
                enc.bytes = {value[7:0], 64'h0};
                enc.count = 4'd1;
            end
            default:
            begin
                enc = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mpk_serializer.sv
`default_nettype none

module mpk_serializer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mpk_pkg::enc_t enc,
    output logic               busy,
    output logic               valid,
    output logic [7:0]         out_byte,
    output logic               last
);
    import mpk_pkg::*;

    logic [8*MaxBytes-1:0] buf_reg;
    logic [8*MaxBytes-1:0] buf_next;
    logic [3:0]            cnt_reg;
    logic [3:0]            cnt_next;
    logic                  load;

    // A new item may load while the final byte of the previous one is shown.
    assign busy     = (cnt_reg > 4'd1);
    assign load     = start && !busy;
    assign valid    = (cnt_reg != 4'd0);
    assign last     = (cnt_reg == 4'd1);
    assign out_byte = buf_reg[8*MaxBytes-1 -: 8];

    always_comb
    begin
        if (load)
        begin
            buf_next = enc.bytes;
            cnt_next = enc.count;
        end
        else if (valid)
        begin
            buf_next = {buf_reg[8*MaxBytes-9:0], 8'h00};
            cnt_next = cnt_reg - 4'd1;
        end
        else
        begin
            buf_next = buf_reg;
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (cnt_reg == $past(cnt_reg) - 4'd1))
        else $error("multi-byte sequence did not advance by one byte");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cnt_reg == $past(enc.count)))
        else $error("accepted item did not load its byte count");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (last && !start) |=> !valid)
        else $error("byte emitted with no item pending");

    a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (valid && !last))
        else $error("busy without a pending non-final byte");

endmodule

`default_nettype wire

// File: rtl/msgpack_value_header_encoder.sv
`default_nettype none

// MessagePack token encoder. An item (func, value, ext_type) is taken at a clock
// edge where start is high and busy is low; its encoded form, 1 to 9 bytes, appears
// on out_byte starting the next cycle, one byte per cycle with valid high, and
// last marks the final byte. Each byte is shown for exactly one cycle and must be
// captured then. Busy is high while the byte shown is not an item's last one, so
// payload bytes and other single-byte tokens go through at one per cycle, and the next
// item can be taken in the cycle that shows the previous item's last byte. The
// rate is set by the single byte lane of the output shift register. Selector
// codes 11 to 15 are accepted and produce no bytes.
module msgpack_value_header_encoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [3:0]        func,
    input  wire logic [63:0]       value,
    input  wire logic signed [7:0] ext_type,
    output logic                   valid,
    output logic [7:0]             out_byte,
    output logic                   last
);
    import mpk_pkg::*;

    enc_t enc;

    mpk_encode u_encode (
        .func     (func),
        .value    (value),
        .ext_type (ext_type),
        .enc      (enc)
    );

    mpk_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .enc      (enc),
        .busy     (busy),
        .valid    (valid),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

`default_nettype wire
